/* rtl/core/rpcg_pkg.sv */
// rpcg_pkg: shared types, register codes and constant tables of the rainbow pixel
// colour generator. The gamma table is built at elaboration from exact integer math.
// No dependencies.
package rpcg_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE        = 3'd0,
    CFG_SOLID_RED   = 3'd1,
    CFG_SOLID_GREEN = 3'd2,
    CFG_SOLID_BLUE  = 3'd3,
    CFG_BRIGHTNESS  = 3'd4
  } cfg_idx_t;

  // mode register codes, the unused code behaves as off
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_SOLID   = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // request class as the front end sorts it
  typedef enum logic [1:0] {
    KIND_OFF     = 2'd0,
    KIND_SOLID   = 2'd1,
    KIND_RAINBOW = 2'd2
  } kind_t;

  localparam int unsigned WHEEL_W     = 11;
  localparam int unsigned WHEEL_STEPS = 1530;
  localparam int unsigned HUE_ROUND   = 32768;
  localparam int unsigned BRIGHT_MAX  = 100;
  localparam int unsigned BRIGHT_MIN  = 1;
  localparam int unsigned SCALE_ROUND = 50;
  // x / 100 == (x * 5243) >> 19 for every x below 43690
  localparam int unsigned DIV100_MUL  = 5243;
  localparam int unsigned DIV100_SHR  = 19;
  localparam int unsigned SUM_W       = 15;

  typedef struct packed {
    kind_t                kind;
    logic [WHEEL_W-1:0]   pos;
  } entry_t;

  typedef struct packed {
    logic [7:0] solid_red;
    logic [7:0] solid_green;
    logic [7:0] solid_blue;
    logic [6:0] brightness;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef logic [7:0] gamma_tab_t [256];

  // level k is reached at input i when i^13 * 32 >= (2k-1)^5 * 255^8
  function automatic logic gamma_reached(input logic [127:0] lhs, input int unsigned k);
    logic [127:0] rhs;
    rhs = 128'd1;
    for (int j = 0; j < 5; j++) begin
      rhs = rhs * 128'(2 * k - 1);
    end
    for (int j = 0; j < 8; j++) begin
      rhs = rhs * 128'd255;
    end
    return lhs >= rhs;
  endfunction

  function automatic gamma_tab_t gamma_build();
    gamma_tab_t   tab;
    logic [127:0] lhs;
    int unsigned  level;
    level = 0;
    for (int i = 0; i < 256; i++) begin
      lhs = 128'd32;
      for (int j = 0; j < 13; j++) begin
        lhs = lhs * 128'(i);
      end
      while (level < 255 && gamma_reached(lhs, level + 1)) begin
        level = level + 1;
      end
      tab[i] = 8'(level);
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_ROM = gamma_build();

endpackage

/* rtl/core/rpcg_fifo.sv */
// rpcg_fifo: small first-word-fall-through queue built from registers.
// Used between the front and back ends and at the result side. No dependencies.
module rpcg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/core/rpcg_front.sv */
// rpcg_front: classifies each request by mode and maps hue plus LED offset onto the
// 1530-step wheel position. Depends on rpcg_pkg.
module rpcg_front import rpcg_pkg::*; #(
  parameter int unsigned LED_COUNT = 64
) (
  input  logic        push,
  input  logic [15:0] frame_hue,
  input  logic [5:0]  led_index,
  input  mode_t       mode,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_wdata
);

  logic [15:0] hue_ofs [64];
  logic [15:0] hue16;
  logic [26:0] wheel_prod;

  // per-index hue offset, index * 65536 / LED_COUNT, worked out at elaboration
  for (genvar j = 0; j < 64; j++) begin : g_ofs
    assign hue_ofs[j] = 16'((j * 65536) / LED_COUNT);
  end

  assign hue16      = frame_hue + hue_ofs[led_index];
  assign wheel_prod = 27'(hue16) * 27'(WHEEL_STEPS) + 27'(HUE_ROUND);

  always_comb begin
    q_wdata.pos = wheel_prod[26:16];
    case (mode)
      MODE_SOLID:   q_wdata.kind = KIND_SOLID;
      MODE_RAINBOW: q_wdata.kind = KIND_RAINBOW;
      default:      q_wdata.kind = KIND_OFF;
    endcase
  end

  assign q_push = push && !q_full;

endmodule

/* rtl/core/rpcg_back.sv */
// rpcg_back: wheel colour, gamma lookup and brightness scaling, one register stage
// deep; one request per clock unless the result queue is full. Depends on rpcg_pkg.
module rpcg_back import rpcg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty,
  input  entry_t q_rdata,
  output logic   q_pop,
  input  cfg_t   cfg,
  input  logic   out_full,
  output logic   out_push,
  output pixel_t out_wdata
);

  logic               a_valid_r;
  logic [SUM_W-1:0]   sum_r_r, sum_g_r, sum_b_r;
  logic [SUM_W-1:0]   sum_r_nxt, sum_g_nxt, sum_b_nxt;
  logic               a_adv;
  logic [WHEEL_W-1:0] pos;
  logic [7:0]         wr, wg, wb;
  logic [7:0]         vr, vg, vb;
  logic [27:0]        qr, qg, qb;

  assign a_adv = !a_valid_r || !out_full;
  assign q_pop = !q_empty && a_adv;
  assign pos   = q_rdata.pos;

  // full-saturation hue wheel
  always_comb begin
    if (pos < WHEEL_W'(510)) begin
      wb = 8'd0;
      if (pos < WHEEL_W'(255)) begin
        wr = 8'd255;
        wg = 8'(pos);
      end else begin
        wr = 8'(WHEEL_W'(510) - pos);
        wg = 8'd255;
      end
    end else if (pos < WHEEL_W'(1020)) begin
      wr = 8'd0;
      if (pos < WHEEL_W'(765)) begin
        wg = 8'd255;
        wb = 8'(pos - WHEEL_W'(510));
      end else begin
        wg = 8'(WHEEL_W'(1020) - pos);
        wb = 8'd255;
      end
    end else if (pos < WHEEL_W'(WHEEL_STEPS)) begin
      wg = 8'd0;
      if (pos < WHEEL_W'(1275)) begin
        wr = 8'(pos - WHEEL_W'(1020));
        wb = 8'd255;
      end else begin
        wr = 8'd255;
        wb = 8'(WHEEL_W'(WHEEL_STEPS) - pos);
      end
    end else begin
      // wheel end wraps to pure red
      wr = 8'd255;
      wg = 8'd0;
      wb = 8'd0;
    end
  end

  always_comb begin
    case (q_rdata.kind)
      KIND_SOLID: begin
        vr = cfg.solid_red;
        vg = cfg.solid_green;
        vb = cfg.solid_blue;
      end
      KIND_RAINBOW: begin
        vr = GAMMA_ROM[wr];
        vg = GAMMA_ROM[wg];
        vb = GAMMA_ROM[wb];
      end
      default: begin
        vr = 8'd0;
        vg = 8'd0;
        vb = 8'd0;
      end
    endcase
    sum_r_nxt = SUM_W'(vr) * SUM_W'(cfg.brightness) + SUM_W'(SCALE_ROUND);
    sum_g_nxt = SUM_W'(vg) * SUM_W'(cfg.brightness) + SUM_W'(SCALE_ROUND);
    sum_b_nxt = SUM_W'(vb) * SUM_W'(cfg.brightness) + SUM_W'(SCALE_ROUND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_adv) begin
      a_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_r_r <= sum_r_nxt;
      sum_g_r <= sum_g_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  // divide by 100 through the reciprocal
  assign qr = 28'(sum_r_r) * 28'(DIV100_MUL);
  assign qg = 28'(sum_g_r) * 28'(DIV100_MUL);
  assign qb = 28'(sum_b_r) * 28'(DIV100_MUL);

  assign out_wdata.red   = qr[DIV100_SHR +: 8];
  assign out_wdata.green = qg[DIV100_SHR +: 8];
  assign out_wdata.blue  = qb[DIV100_SHR +: 8];
  assign out_push        = a_valid_r && !out_full;

endmodule

/* rtl/core/rainbow_pixel_colour_generator.sv */
// rainbow_pixel_colour_generator: top level with configuration registers, the front
// end, the request queue, the back end and the result queue. Depends on rpcg_pkg.
//
//   channel   direction  handshake           payload
//   in_       request    in_push / in_full   in_frame_hue, in_led_index
//   out_      result     out_pop / out_empty out_red, out_green, out_blue
//   cfg_      config     cfg_we              cfg_idx, cfg_wdata
//
// one request per clock sustained while results are taken; a result shows on out_
// after passing the request queue, the scaling stage, then the result queue register
// reset is synchronous; it empties both queues and loads the register defaults
// a held result stalls the scaling stage, then the request queue, then in_full
// the gamma table is constant logic, so no clearing pass follows reset
module rainbow_pixel_colour_generator import rpcg_pkg::*; #(
  parameter int unsigned LED_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_frame_hue,
  input  logic [5:0]  in_led_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  mode_t      mode_r;
  cfg_t       cfg_r;
  logic [6:0] bright_w;
  logic       q_push, q_pop, q_full, q_empty;
  entry_t     q_wdata, q_rdata;
  logic       o_push, o_full;
  pixel_t     o_wdata, o_rdata;

  // out-of-range brightness in cfg_wdata[6:0] saturates to 1..100; bit 7 is ignored
  always_comb begin
    bright_w = cfg_wdata[6:0];
    if (bright_w < 7'(BRIGHT_MIN)) begin
      bright_w = 7'(BRIGHT_MIN);
    end else if (bright_w > 7'(BRIGHT_MAX)) begin
      bright_w = 7'(BRIGHT_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= MODE_OFF;
      cfg_r.solid_red   <= 8'd0;
      cfg_r.solid_green <= 8'd0;
      cfg_r.solid_blue  <= 8'd0;
      cfg_r.brightness  <= 7'(BRIGHT_MAX);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE:        mode_r            <= mode_t'(cfg_wdata[1:0]);
        CFG_SOLID_RED:   cfg_r.solid_red   <= cfg_wdata;
        CFG_SOLID_GREEN: cfg_r.solid_green <= cfg_wdata;
        CFG_SOLID_BLUE:  cfg_r.solid_blue  <= cfg_wdata;
        CFG_BRIGHTNESS:  cfg_r.brightness  <= bright_w;
        default: ;
      endcase
    end
  end

  rpcg_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .push      (in_push),
    .frame_hue (in_frame_hue),
    .led_index (in_led_index),
    .mode      (mode_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  rpcg_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (2)
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rpcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_full  (o_full),
    .out_push  (o_push),
    .out_wdata (o_wdata)
  );

  rpcg_fifo #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_wdata),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (o_rdata),
    .empty (out_empty)
  );

  assign in_full   = q_full;
  assign out_red   = o_rdata.red;
  assign out_green = o_rdata.green;
  assign out_blue  = o_rdata.blue;

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.brightness >= 7'(BRIGHT_MIN) && cfg_r.brightness <= 7'(BRIGHT_MAX))
    else $error("brightness register out of range");

  a_bright_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_idx == CFG_BRIGHTNESS && cfg_wdata[6:0] == 7'd0
    |=> cfg_r.brightness == 7'(BRIGHT_MIN))
    else $error("zero brightness write did not saturate");

  a_req_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> !q_empty)
    else $error("accepted request missing from queue");

  a_res_queued: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |=> !out_empty)
    else $error("finished result missing from result queue");

endmodule
